// ===== design/smra_pkg.sv =====
package smra_pkg;

  localparam int MAX_BYTES_DEF = 32;
  localparam int BITS_PER_BYTE = 8;

  localparam logic [7:0] CS_SETUP_RST  = 8'd5;
  localparam logic [7:0] CLK_LOW_RST   = 8'd5;
  localparam logic [7:0] CLK_HIGH_RST  = 8'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_CS_SETUP = 2'd0,
    CFG_CLK_LOW  = 2'd1,
    CFG_CLK_HIGH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] reg_address;
    logic [5:0] byte_count;
    logic [7:0] write_byte;
    logic       miso_level;
  } in_t;

  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       mosi_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       last_byte;
    logic       busy_res;
    logic       rejected;
  } out_t;

  typedef struct packed {
    logic [7:0] cs_setup_ticks;
    logic [7:0] clock_low_ticks;
    logic [7:0] clock_high_ticks;
  } timing_t;

endpackage

// ===== design/spi_master_register_access.sv =====
// SPI mode 3 register-access master. Every input beat is one tick of pin timing and
// yields exactly one output beat with the pin levels after that tick, any received
// byte and the busy and rejected flags. A beat enters an input register and its result
// is computed in one pass into an output register, so one beat is taken per cycle
// while the output is not stalled; stalls come only from output backpressure. The
// write buffer holds MAX_BYTES bytes in a memory with one write port and one
// registered read port, prefetched a byte ahead of the shifter. Timing registers are
// written through the configuration channel, which is always ready; the user must
// write them only while no beat is in flight, as the block itself does not enforce it.
module spi_master_register_access #(
  parameter int MAX_BYTES = smra_pkg::MAX_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  smra_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output smra_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  logic              in_valid_q;
  smra_pkg::in_t     in_q;
  logic              out_valid_q;
  smra_pkg::out_t    out_q;
  logic              step;
  smra_pkg::out_t    res;
  smra_pkg::timing_t timing;

  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign cfg_ready_o = 1'b1;

  smra_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .timing_o    (timing)
  );

  smra_core #(
    .MAX_BYTES (MAX_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .timing_i (timing),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/smra_cfg.sv =====
module smra_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  output smra_pkg::timing_t timing_o
);

  smra_pkg::timing_t timing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q.cs_setup_ticks   <= smra_pkg::CS_SETUP_RST;
      timing_q.clock_low_ticks  <= smra_pkg::CLK_LOW_RST;
      timing_q.clock_high_ticks <= smra_pkg::CLK_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (smra_pkg::cfg_idx_e'(cfg_index_i))
        smra_pkg::CFG_CS_SETUP: timing_q.cs_setup_ticks   <= cfg_data_i;
        smra_pkg::CFG_CLK_LOW:  timing_q.clock_low_ticks  <= cfg_data_i;
        smra_pkg::CFG_CLK_HIGH: timing_q.clock_high_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign timing_o = timing_q;

endmodule

// ===== design/smra_core.sv =====
module smra_core #(
  parameter int MAX_BYTES = smra_pkg::MAX_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  smra_pkg::in_t     item_i,
  input  smra_pkg::timing_t timing_i,
  output smra_pkg::out_t    res_o
);

  localparam int CW = $clog2(MAX_BYTES + 1);
  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int NW = (CW > 6) ? CW : 6;
  localparam logic [2:0] LAST_BIT = 3'(smra_pkg::BITS_PER_BYTE - 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETUP,
    PH_LOW,
    PH_HIGH
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [7:0]     tick_q, tick_d;
  logic [2:0]     bit_q, bit_d;
  logic [CW-1:0]  idx_q, idx_d;
  logic [CW-1:0]  total_q, total_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic           is_read_q, is_read_d;
  logic           in_addr_q, in_addr_d;
  logic [7:0]     sout_q, sout_d;
  logic [7:0]     sin_q, sin_d;
  logic           cs_n_q, cs_n_d;
  logic           sclk_q, sclk_d;
  logic           mosi_q, mosi_d;

  logic [7:0]     mem_q [MAX_BYTES];
  logic [7:0]     rd_q;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  logic [7:0]     tick_inc;
  logic [CW-1:0]  idx_next;
  logic [7:0]     next_byte;
  logic [NW-1:0]  cnt_ext;
  logic           is_rd_op;
  logic           bad_cnt;
  logic           rej, rvalid, rlast;
  logic [7:0]     rbyte;

  assign rd_addr = in_addr_q ? '0 : AW'(idx_q + CW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fill_q[AW-1:0]] <= item_i.write_byte;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    total_d   = total_q;
    fill_d    = fill_q;
    is_read_d = is_read_q;
    in_addr_d = in_addr_q;
    sout_d    = sout_q;
    sin_d     = sin_q;
    cs_n_d    = cs_n_q;
    sclk_d    = sclk_q;
    mosi_d    = mosi_q;
    mem_we    = 1'b0;
    rej       = 1'b0;
    rvalid    = 1'b0;
    rlast     = 1'b0;
    rbyte     = '0;
    tick_inc  = tick_q + 8'd1;
    idx_next  = in_addr_q ? '0 : idx_q + CW'(1);
    next_byte = is_read_q ? 8'h00 : rd_q;
    cnt_ext   = NW'(item_i.byte_count);
    is_rd_op  = (item_i.opcode == smra_pkg::OP_READ);
    bad_cnt   = (cnt_ext == '0) || (cnt_ext > NW'(MAX_BYTES)) ||
                (!is_rd_op && (cnt_ext > NW'(fill_q)));

    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        if (item_i.opcode == smra_pkg::OP_PUSH) begin
          if (fill_q >= CW'(MAX_BYTES)) begin
            rej = 1'b1;
          end else begin
            mem_we = 1'b1;
            fill_d = fill_q + CW'(1);
          end
        end else if (item_i.opcode == smra_pkg::OP_WRITE ||
                     item_i.opcode == smra_pkg::OP_READ) begin
          if (bad_cnt) begin
            rej = 1'b1;
          end else begin
            if (!is_rd_op) begin
              fill_d = '0;
            end
            is_read_d = is_rd_op;
            in_addr_d = 1'b1;
            total_d   = CW'(item_i.byte_count);
            idx_d     = '0;
            bit_d     = '0;
            sout_d    = item_i.reg_address;
            sin_d     = '0;
            tick_d    = '0;
            phase_d   = PH_SETUP;
            cs_n_d    = 1'b0;
            sclk_d    = 1'b1;
            mosi_d    = 1'b0;
          end
        end
      end else begin
        rej    = (item_i.opcode != smra_pkg::OP_TICK);
        tick_d = tick_inc;
        case (phase_q)
          PH_SETUP: begin
            if (tick_inc >= timing_i.cs_setup_ticks) begin
              phase_d = PH_LOW;
              tick_d  = '0;
              sclk_d  = 1'b0;
              mosi_d  = sout_q[7];
            end
          end
          PH_LOW: begin
            if (tick_inc >= timing_i.clock_low_ticks) begin
              if (is_read_q && !in_addr_q) begin
                sin_d = {sin_q[6:0], item_i.miso_level};
                if (bit_q == LAST_BIT) begin
                  rvalid = 1'b1;
                  rbyte  = sin_d;
                  rlast  = ((idx_q + CW'(1)) == total_q);
                end
              end
              phase_d = PH_HIGH;
              tick_d  = '0;
              sclk_d  = 1'b1;
            end
          end
          PH_HIGH: begin
            if (tick_inc >= timing_i.clock_high_ticks) begin
              bit_d  = bit_q + 3'd1;
              sout_d = {sout_q[6:0], 1'b0};
              tick_d = '0;
              if (bit_q == LAST_BIT) begin
                in_addr_d = 1'b0;
                idx_d     = idx_next;
                if (idx_next >= total_q) begin
                  phase_d = PH_IDLE;
                  cs_n_d  = 1'b1;
                  sclk_d  = 1'b1;
                  mosi_d  = 1'b0;
                end else begin
                  sout_d  = next_byte;
                  phase_d = PH_LOW;
                  sclk_d  = 1'b0;
                  mosi_d  = next_byte[7];
                end
              end else begin
                phase_d = PH_LOW;
                sclk_d  = 1'b0;
                mosi_d  = sout_q[6];
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      bit_q     <= '0;
      idx_q     <= '0;
      total_q   <= '0;
      fill_q    <= '0;
      is_read_q <= 1'b0;
      in_addr_q <= 1'b0;
      sout_q    <= '0;
      sin_q     <= '0;
      cs_n_q    <= 1'b1;
      sclk_q    <= 1'b1;
      mosi_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      bit_q     <= bit_d;
      idx_q     <= idx_d;
      total_q   <= total_d;
      fill_q    <= fill_d;
      is_read_q <= is_read_d;
      in_addr_q <= in_addr_d;
      sout_q    <= sout_d;
      sin_q     <= sin_d;
      cs_n_q    <= cs_n_d;
      sclk_q    <= sclk_d;
      mosi_q    <= mosi_d;
    end
  end

  always_comb begin
    res_o.chip_select_n = cs_n_d;
    res_o.serial_clock  = sclk_d;
    res_o.mosi_level    = mosi_d;
    res_o.read_byte     = rbyte;
    res_o.read_valid    = rvalid;
    res_o.last_byte     = rlast;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.rejected      = rej;
  end

endmodule

// ===== design/smra_checker.sv =====
module smra_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input smra_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  a_cs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.busy_res != out_data_o.chip_select_n))
    else $error("chip select disagrees with busy");

  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.busy_res |->
      out_data_o.serial_clock && !out_data_o.mosi_level && !out_data_o.read_valid)
    else $error("pins not at idle levels");

  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.read_valid |->
      (out_data_o.read_byte == 8'h00) && !out_data_o.last_byte)
    else $error("read data without a read beat");

endmodule

bind spi_master_register_access smra_checker u_smra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ===== dv/spi_master_register_access_tb.sv =====
`timescale 1ns / 1ps

module spi_master_register_access_tb;

  localparam int RANDOM_BEATS = 600;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SETUP,
    PH_LOW,
    PH_HIGH
  } xfer_phase_e;

  class spi_access_tracker;
    smra_pkg::timing_t timing;
    xfer_phase_e       phase;
    logic [7:0]        tick_cnt;
    logic [2:0]        bit_cnt;
    logic [5:0]        byte_idx;
    logic [5:0]        total_bytes;
    logic [5:0]        fill_cnt;
    logic              is_read;
    logic              in_addr;
    logic [7:0]        shift_out;
    logic [7:0]        shift_in;
    logic [7:0]        wbuf [smra_pkg::MAX_BYTES_DEF];
    logic              cs_n;
    logic              sclk;
    logic              mosi;
    smra_pkg::out_t    expected_pins_q[$];
    int                errors;

    function new();
      timing      = '{smra_pkg::CS_SETUP_RST, smra_pkg::CLK_LOW_RST, smra_pkg::CLK_HIGH_RST};
      phase       = PH_IDLE;
      tick_cnt    = '0;
      bit_cnt     = '0;
      byte_idx    = '0;
      total_bytes = '0;
      fill_cnt    = '0;
      is_read     = 1'b0;
      in_addr     = 1'b0;
      shift_out   = '0;
      shift_in    = '0;
      cs_n        = 1'b1;
      sclk        = 1'b1;
      mosi        = 1'b0;
      errors      = 0;
    endfunction

    function void write_reg(smra_pkg::cfg_idx_e idx, logic [7:0] val);
      case (idx)
        smra_pkg::CFG_CS_SETUP: timing.cs_setup_ticks = val;
        smra_pkg::CFG_CLK_LOW:  timing.clock_low_ticks = val;
        smra_pkg::CFG_CLK_HIGH: timing.clock_high_ticks = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_pins_q.size();
    endfunction

    function void drop_clock();
      phase    = PH_LOW;
      tick_cnt = '0;
      sclk     = 1'b0;
      mosi     = shift_out[7];
    endfunction

    function void take_beat(smra_pkg::in_t b);
      smra_pkg::out_t r;
      logic rd;
      r = '0;
      if (phase == PH_IDLE) begin
        if (b.opcode == smra_pkg::OP_PUSH) begin
          if (fill_cnt >= smra_pkg::MAX_BYTES_DEF) begin
            r.rejected = 1'b1;
          end else begin
            wbuf[fill_cnt] = b.write_byte;
            fill_cnt++;
          end
        end else if (b.opcode != smra_pkg::OP_TICK) begin
          rd = (b.opcode == smra_pkg::OP_READ);
          if (b.byte_count == 0 || b.byte_count > smra_pkg::MAX_BYTES_DEF ||
              (!rd && b.byte_count > fill_cnt)) begin
            r.rejected = 1'b1;
          end else begin
            if (!rd) fill_cnt = '0;
            is_read     = rd;
            in_addr     = 1'b1;
            total_bytes = b.byte_count;
            byte_idx    = '0;
            bit_cnt     = '0;
            shift_out   = b.reg_address;
            shift_in    = '0;
            tick_cnt    = '0;
            phase       = PH_SETUP;
            cs_n        = 1'b0;
            sclk        = 1'b1;
            mosi        = 1'b0;
          end
        end
      end else begin
        if (b.opcode != smra_pkg::OP_TICK) r.rejected = 1'b1;
        tick_cnt++;
        case (phase)
          PH_SETUP: begin
            if (tick_cnt >= timing.cs_setup_ticks) drop_clock();
          end
          PH_LOW: begin
            if (tick_cnt >= timing.clock_low_ticks) begin
              if (is_read && !in_addr) begin
                shift_in = {shift_in[6:0], b.miso_level};
                if (bit_cnt == 3'd7) begin
                  r.read_valid = 1'b1;
                  r.read_byte  = shift_in;
                  r.last_byte  = (byte_idx + 1 == total_bytes);
                end
              end
              phase    = PH_HIGH;
              tick_cnt = '0;
              sclk     = 1'b1;
            end
          end
          default: begin
            if (tick_cnt >= timing.clock_high_ticks) begin
              bit_cnt++;
              shift_out = shift_out << 1;
              if (bit_cnt == 0) begin
                if (in_addr) begin
                  in_addr  = 1'b0;
                  byte_idx = '0;
                end else begin
                  byte_idx++;
                end
                if (byte_idx >= total_bytes) begin
                  phase    = PH_IDLE;
                  tick_cnt = '0;
                  cs_n     = 1'b1;
                  sclk     = 1'b1;
                  mosi     = 1'b0;
                end else begin
                  shift_out = is_read ? 8'h00 : wbuf[byte_idx];
                  drop_clock();
                end
              end else begin
                drop_clock();
              end
            end
          end
        endcase
      end
      r.chip_select_n = cs_n;
      r.serial_clock  = sclk;
      r.mosi_level    = mosi;
      r.busy_res      = (phase != PH_IDLE);
      expected_pins_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t ns: %s", $time, msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task check_pins(smra_pkg::out_t got);
      smra_pkg::out_t want;
      if (expected_pins_q.size() == 0) begin
        report("output beat with nothing expected");
        return;
      end
      want = expected_pins_q.pop_front();
      check_field("chip_select_n", got.chip_select_n, want.chip_select_n);
      check_field("serial_clock", got.serial_clock, want.serial_clock);
      check_field("mosi_level", got.mosi_level, want.mosi_level);
      check_field("read_byte", got.read_byte, want.read_byte);
      check_field("read_valid", got.read_valid, want.read_valid);
      check_field("last_byte", got.last_byte, want.last_byte);
      check_field("busy_res", got.busy_res, want.busy_res);
      check_field("rejected", got.rejected, want.rejected);
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  smra_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  smra_pkg::out_t out_data_o;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index_i = '0;
  logic [7:0]     cfg_data_i = '0;

  int send_idle_pct = 6;
  int recv_idle_pct = 61;
  int beats_sent = 0;

  spi_access_tracker sb = new();

  spi_master_register_access i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_pins(out_data_o);
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic smra_pkg::in_t beat(smra_pkg::opcode_e op, logic [7:0] addr,
                                         logic [5:0] cnt, logic [7:0] wb, logic miso);
    smra_pkg::in_t b;
    b.opcode      = op;
    b.reg_address = addr;
    b.byte_count  = cnt;
    b.write_byte  = wb;
    b.miso_level  = miso;
    return b;
  endfunction

  function automatic smra_pkg::in_t rand_beat(smra_pkg::opcode_e op);
    return beat(op, 8'($urandom_range(255)), 6'($urandom_range(63)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
  endfunction

  function automatic int xfer_len();
    return ($urandom_range(9) == 0) ? $urandom_range(1, smra_pkg::MAX_BYTES_DEF)
                                    : $urandom_range(1, 2);
  endfunction

  function automatic logic [7:0] rand_timing();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'($urandom_range(3, 10));
    return 8'($urandom_range(1, 2));
  endfunction

  task automatic send_beat(smra_pkg::in_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_beat(b);
    beats_sent++;
  endtask

  task automatic start_xfer(smra_pkg::opcode_e op, logic [5:0] cnt);
    smra_pkg::in_t b;
    b = rand_beat(op);
    b.byte_count = cnt;
    send_beat(b);
  endtask

  // tick until the transfer ends, sometimes with a command on the tick
  task automatic finish_xfer(int noise_pct);
    smra_pkg::in_t b;
    while (sb.phase != PH_IDLE) begin
      b = rand_beat(smra_pkg::OP_TICK);
      if ($urandom_range(99) < noise_pct) begin
        b.opcode = smra_pkg::opcode_e'($urandom_range(1, 3));
      end
      send_beat(b);
    end
  endtask

  task automatic quiesce();
    finish_xfer(0);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timing(logic [7:0] cs, logic [7:0] lo, logic [7:0] hi);
    logic [7:0] vals [3];
    vals = '{cs, lo, hi};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= smra_pkg::cfg_idx_e'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(smra_pkg::cfg_idx_e'(i), vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_xfer();
    smra_pkg::in_t b;
    int  kind;
    int  n;
    kind = $urandom_range(99);
    if (kind < 45) begin
      n = xfer_len();
      repeat (n) send_beat(rand_beat(smra_pkg::OP_PUSH));
      b = rand_beat(smra_pkg::OP_WRITE);
      if ($urandom_range(3) == 0) b.byte_count = 6'($urandom_range(1, sb.fill_cnt));
      else b.byte_count = 6'((n < sb.fill_cnt) ? n : sb.fill_cnt);
      send_beat(b);
    end else if (kind < 85) begin
      start_xfer(smra_pkg::OP_READ, 6'(xfer_len()));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        send_beat(rand_beat(smra_pkg::opcode_e'($urandom_range(3))));
      end
    end
    finish_xfer(5);
    repeat ($urandom_range(3)) send_beat(rand_beat(smra_pkg::OP_TICK));
  endtask

  initial begin
    #4ms;
    $display("spi_master_register_access test failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(beat(smra_pkg::OP_TICK, 8'hFF, 6'h3F, 8'hFF, 1'b1));
    send_beat(beat(smra_pkg::OP_TICK, 8'h00, 6'h00, 8'h00, 1'b0));
    start_xfer(smra_pkg::OP_WRITE, 6'd0);
    start_xfer(smra_pkg::OP_READ, 6'd0);
    start_xfer(smra_pkg::OP_READ, 6'd33);
    start_xfer(smra_pkg::OP_READ, 6'h3F);
    start_xfer(smra_pkg::OP_WRITE, 6'd1);
    send_beat(beat(smra_pkg::OP_READ, 8'hFF, 6'd1, 8'h00, 1'b1));
    send_beat(rand_beat(smra_pkg::OP_PUSH));
    start_xfer(smra_pkg::OP_WRITE, 6'd1);
    start_xfer(smra_pkg::OP_READ, 6'd1);
    quiesce();

    set_timing(8'd1, 8'd1, 8'd1);
    send_beat(beat(smra_pkg::OP_PUSH, 8'h00, 6'h00, 8'h00, 1'b0));
    send_beat(beat(smra_pkg::OP_PUSH, 8'hFF, 6'h3F, 8'hFF, 1'b1));
    repeat (31) send_beat(rand_beat(smra_pkg::OP_PUSH));
    start_xfer(smra_pkg::OP_WRITE, 6'd33);
    send_beat(beat(smra_pkg::OP_WRITE, 8'hA5, 6'd32, 8'h00, 1'b0));
    finish_xfer(0);
    start_xfer(smra_pkg::OP_WRITE, 6'd1);
    send_beat(beat(smra_pkg::OP_READ, 8'h5A, 6'd32, 8'h00, 1'b0));
    finish_xfer(0);
    quiesce();

    set_timing(8'd0, 8'd0, 8'd0);
    send_beat(rand_beat(smra_pkg::OP_PUSH));
    start_xfer(smra_pkg::OP_WRITE, 6'd1);
    finish_xfer(0);
    start_xfer(smra_pkg::OP_READ, 6'd1);
    quiesce();

    set_timing(8'd255, 8'd1, 8'd1);
    start_xfer(smra_pkg::OP_READ, 6'd1);
    quiesce();

    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (beats_sent < RANDOM_BEATS / 3) begin
        send_idle_pct = 6;
        recv_idle_pct = 61;
      end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      quiesce();
      set_timing(rand_timing(), rand_timing(), rand_timing());
      repeat ($urandom_range(2, 5)) random_xfer();
    end

    quiesce();
    repeat (10) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("spi_master_register_access test passed");
    end else begin
      $display("spi_master_register_access test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/smra_pkg.sv
design/smra_cfg.sv
design/smra_core.sv
design/spi_master_register_access.sv
design/smra_checker.sv
dv/spi_master_register_access_tb.sv
